@@ sv/rsblit_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsblit_pkg
// Shared types, constants and helpers of the rotated sprite blitter.
// ----------------------------------------------------------------------------
package rsblit_pkg;

  // Screen and window limits.
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;
  localparam int unsigned MAX_WINDOW    = 64;

  // Width of the column and row counters.
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW);
  // Width of a window size register.
  localparam int unsigned SIZE_W  = 7;
  // Width of a signed screen coordinate before clipping.
  localparam int unsigned COORD_W = 14;
  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X      = 3'd0,
    CFG_CENTRE_Y      = 3'd1,
    CFG_WINDOW_WIDTH  = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_FACING        = 3'd4
  } cfg_idx_e;

  // Sprite orientation.
  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_EAST  = 2'd3
  } facing_e;

  // One texel word on the input channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       opaque;
  } texel_t;

  // One pixel write word on the output channel.
  typedef struct packed {
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pixel_t;

  // A size of zero counts as one; sizes above the limit saturate.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] res;
    res = size;
    if (size == '0) begin
      res = SIZE_W'(1);
    end else if (size > SIZE_W'(MAX_WINDOW)) begin
      res = SIZE_W'(MAX_WINDOW);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ sv/rotated_sprite_blit_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_sprite_blit_top
// Sprite blitter with quarter-turn rotation, colour key and screen clipping.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  texel    | in_valid_i, in_stall_o, in_texel_i       | in
//  pixel    | out_valid_o, out_stall_i, out_pixel_o    | out
//  config   | cfg_we_i, cfg_index_i, cfg_data_i        | in
//
// One texel word is taken per cycle while in_stall_o is low; it passes the texel register, then the pixel register.
// The texel register holds the word and its window position; the mapping and
// clip logic sits between it and the pixel register.
// Transparent and off-screen texels are dropped at the texel register and
// never stall the input. Reset clears the counters and loads the register
// defaults. A stall on the output backs up into in_stall_o in the same cycle.
module rotated_sprite_blit_top
  import rsblit_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire texel_t                in_texel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pixel_t                     out_pixel_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic signed [11:0] centre_x_q;
  logic signed [11:0] centre_y_q;
  logic [SIZE_W-1:0]  width_q;
  logic [SIZE_W-1:0]  height_q;
  facing_e            facing_q;
  logic               cfg_hit;

  // Window position counters.
  logic [CNT_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]   row_q, row_d;
  logic [SIZE_W-1:0]  win_w, win_h;

  // Texel register.
  logic               s1_valid_q;
  texel_t             s1_texel_q;
  logic [CNT_W-1:0]   s1_col_q, s1_row_q;

  // Mapping and clipping.
  logic               swap;
  logic [SIZE_W-1:0]  half_x, half_y;
  logic [SIZE_W-1:0]  ox, oy;
  logic signed [COORD_W-1:0] left, top, pos_x, pos_y;
  logic               on_screen, s1_hit;

  // Handshake.
  logic               in_accept, out_free, s1_advance;

  // Pixel register.
  logic               out_valid_q;
  pixel_t             out_pixel_q;

  assign win_w = clamp_size(width_q);
  assign win_h = clamp_size(height_q);

  // A write to a listed register is taken; other indexes are ignored.
  always_comb begin
    case (cfg_index_i)
      CFG_CENTRE_X, CFG_CENTRE_Y, CFG_WINDOW_WIDTH,
      CFG_WINDOW_HEIGHT, CFG_FACING: cfg_hit = cfg_we_i;
      default:                       cfg_hit = 1'b0;
    endcase
  end

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      width_q    <= SIZE_W'(1);
      height_q   <= SIZE_W'(1);
      facing_q   <= FACE_NORTH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTRE_X:      centre_x_q <= signed'(cfg_data_i);
        CFG_CENTRE_Y:      centre_y_q <= signed'(cfg_data_i);
        CFG_WINDOW_WIDTH:  width_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_WINDOW_HEIGHT: height_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_FACING:        facing_q   <= facing_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Raster counters: an accepted texel steps the column, wrapping into rows, unless a listed register is written.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if ((SIZE_W'(col_q) + SIZE_W'(1)) >= win_w) begin
        col_d = '0;
        if ((SIZE_W'(row_q) + SIZE_W'(1)) >= win_h) begin
          row_d = '0;
        end else begin
          row_d = row_q + CNT_W'(1);
        end
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The texel register drains whenever its word will not need the pixel register or the pixel register is free.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_advance = !s1_valid_q || !s1_hit || out_free;
  assign in_stall_o = !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_texel_q <= in_texel_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
    end
  end

  // Top-left corner and rotated offset of the registered texel.
  always_comb begin
    swap   = (facing_q == FACE_WEST) || (facing_q == FACE_EAST);
    half_x = swap ? (win_h >> 1) : (win_w >> 1);
    half_y = swap ? (win_w >> 1) : (win_h >> 1);
    left   = COORD_W'(centre_x_q) - signed'(COORD_W'(half_x));
    top    = COORD_W'(centre_y_q) - signed'(COORD_W'(half_y));
    case (facing_q)
      FACE_NORTH: begin
        ox = SIZE_W'(s1_col_q);
        oy = SIZE_W'(s1_row_q);
      end
      FACE_WEST: begin
        ox = SIZE_W'(s1_row_q);
        oy = win_w - SIZE_W'(s1_col_q) - SIZE_W'(1);
      end
      FACE_SOUTH: begin
        ox = win_w - SIZE_W'(s1_col_q) - SIZE_W'(1);
        oy = win_h - SIZE_W'(s1_row_q) - SIZE_W'(1);
      end
      default: begin
        ox = win_h - SIZE_W'(s1_row_q) - SIZE_W'(1);
        oy = SIZE_W'(s1_col_q);
      end
    endcase
    pos_x = left + signed'(COORD_W'(ox));
    pos_y = top + signed'(COORD_W'(oy));
  end

  // Clip against the screen and apply the colour key.
  assign on_screen = !pos_x[COORD_W-1] && !pos_y[COORD_W-1]
                  && (unsigned'(pos_x) < COORD_W'(SCREEN_WIDTH))
                  && (unsigned'(pos_y) < COORD_W'(SCREEN_HEIGHT));
  assign s1_hit    = s1_texel_q.opaque && on_screen;

  // Pixel register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && s1_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q && s1_hit) begin
      out_pixel_q.pixel_x   <= pos_x[8:0];
      out_pixel_q.pixel_y   <= pos_y[7:0];
      out_pixel_q.out_red   <= s1_texel_q.red;
      out_pixel_q.out_green <= s1_texel_q.green;
      out_pixel_q.out_blue  <= s1_texel_q.blue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

`ifndef SYNTHESIS
  // The counters always lie inside the current window.
  a_col_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SIZE_W'(col_q) < win_w)
    else $error("column counter outside the window");

  a_row_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SIZE_W'(row_q) < win_h)
    else $error("row counter outside the window");

  // A write to a listed register restarts the raster.
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared by a configuration write");

  // An accepted texel always lands in the texel register.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted texel lost");

  // Only clipped positions reach the output.
  a_out_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_pixel_q.pixel_x) < SCREEN_WIDTH)
                 && (32'(out_pixel_q.pixel_y) < SCREEN_HEIGHT))
    else $error("pixel write off screen");
`endif

endmodule
`default_nettype wire

@@ tb/rotated_sprite_blit_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sprite_blit_top_tb
// Self-checking testbench for the rotated sprite blitter. Texel words are
// streamed under a range of window, centre and facing settings; a scoreboard
// predicts the pixel word each texel should produce and checks the output
// stream in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module rotated_sprite_blit_top_tb
  import rsblit_pkg::*;
();

  // Run length and timing.
  localparam int TOTAL_ITEMS   = 1700;
  localparam int CALM_ITEMS    = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 250;
  localparam int CYCLE_LIMIT   = 300000;

  // Register indexes past the end of the register list; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // Predicts the pixel word for each accepted texel and checks the output stream.
  class pixel_scoreboard;
    logic signed [CFG_DATA_W-1:0] centre_x;
    logic signed [CFG_DATA_W-1:0] centre_y;
    logic [SIZE_W-1:0]            window_w;
    logic [SIZE_W-1:0]            window_h;
    facing_e                      facing;
    int                           column;
    int                           row;
    pixel_t                       expected_pixels[$];
    int                           mismatches;
    int                           texels_seen;
    int                           pixels_checked;

    function new();
      centre_x       = '0;
      centre_y       = '0;
      window_w       = SIZE_W'(1);
      window_h       = SIZE_W'(1);
      facing         = FACE_NORTH;
      column         = 0;
      row            = 0;
      mismatches     = 0;
      texels_seen    = 0;
      pixels_checked = 0;
    endfunction

    // A zero size behaves as one; anything above the largest window saturates.
    function int effective_size(int size);
      if (size == 0) return 1;
      if (size > int'(MAX_WINDOW)) return int'(MAX_WINDOW);
      return size;
    endfunction

    // Any write to a real register restarts the window scan.
    function void register_written(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
      bit known;
      known = 1'b1;
      case (index)
        CFG_CENTRE_X:      centre_x = data;
        CFG_CENTRE_Y:      centre_y = data;
        CFG_WINDOW_WIDTH:  window_w = data[SIZE_W-1:0];
        CFG_WINDOW_HEIGHT: window_h = data[SIZE_W-1:0];
        CFG_FACING:        facing = facing_e'(data[1:0]);
        default:           known = 1'b0;
      endcase
      if (known) begin
        column = 0;
        row    = 0;
      end
    endfunction

    // Map the texel at the current scan position to the screen and step the scan.
    function void texel_accepted(texel_t texel);
      int     w, h, left, top, ox, oy, x, y;
      pixel_t pix;
      w = effective_size(window_w);
      h = effective_size(window_h);
      if (facing == FACE_WEST || facing == FACE_EAST) begin
        left = int'(centre_x) - h / 2;
        top  = int'(centre_y) - w / 2;
      end else begin
        left = int'(centre_x) - w / 2;
        top  = int'(centre_y) - h / 2;
      end
      case (facing)
        FACE_NORTH: begin
          ox = column;
          oy = row;
        end
        FACE_WEST: begin
          ox = row;
          oy = w - 1 - column;
        end
        FACE_SOUTH: begin
          ox = w - 1 - column;
          oy = h - 1 - row;
        end
        default: begin
          ox = h - 1 - row;
          oy = column;
        end
      endcase
      x = left + ox;
      y = top + oy;
      if (texel.opaque && x >= 0 && y >= 0 &&
          x < int'(SCREEN_WIDTH) && y < int'(SCREEN_HEIGHT)) begin
        pix.pixel_x   = x[8:0];
        pix.pixel_y   = y[7:0];
        pix.out_red   = texel.red;
        pix.out_green = texel.green;
        pix.out_blue  = texel.blue;
        expected_pixels.push_back(pix);
      end
      texels_seen++;
      if (column + 1 >= w) begin
        column = 0;
        if (row + 1 >= h) row = 0;
        else row++;
      end else begin
        column++;
      end
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $error("pixel word field %s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Every pixel word must match the oldest outstanding prediction.
    function void pixel_arrived(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel word (%0d, %0d) arrived with none expected",
               got.pixel_x, got.pixel_y);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      compare("pixel_x", want.pixel_x, got.pixel_x);
      compare("pixel_y", want.pixel_y, got.pixel_y);
      compare("out_red", want.out_red, got.out_red);
      compare("out_green", want.out_green, got.out_green);
      compare("out_blue", want.out_blue, got.out_blue);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  texel_t                in_texel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pixel_t                out_pixel;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb;
  int  src_idle_pct = 0;
  int  sink_idle_pct = 0;
  bit  long_hold_req = 1'b0;
  int  hold_left = 0;
  int  sink_burst = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  settings_used = 0;

  rotated_sprite_blit_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_texel_i  (in_texel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_pixel_o (out_pixel),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixel words still expected",
               cycle_count, sb.expected_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Pixel sink: a long hold-off when asked for, otherwise random stall bursts.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
      if (hold_left == 0) long_hold_req = 1'b0;
    end else if (long_hold_req) begin
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (sink_burst > 0) begin
      sink_burst = sink_burst - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      sink_burst = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each pixel word as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.pixel_arrived(out_pixel);
  end

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Mostly small windows, some up to the limit, a few zero or oversized.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 12);
    if (r < 9) return $urandom_range(13, 64);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(65, 127);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.register_written(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write all five registers; unused upper data bits carry random values.
  task automatic configure(input int cx, input int cy, input int w, input int h,
                           input facing_e f);
    logic [CFG_DATA_W-1:0] d;
    write_reg(CFG_CENTRE_X, CFG_DATA_W'(cx));
    write_reg(CFG_CENTRE_Y, CFG_DATA_W'(cy));
    d = CFG_DATA_W'($urandom);
    d[SIZE_W-1:0] = SIZE_W'(w);
    write_reg(CFG_WINDOW_WIDTH, d);
    d = CFG_DATA_W'($urandom);
    d[SIZE_W-1:0] = SIZE_W'(h);
    write_reg(CFG_WINDOW_HEIGHT, d);
    d = CFG_DATA_W'($urandom);
    d[1:0] = f;
    write_reg(CFG_FACING, d);
    settings_used++;
  endtask

  // Offer one texel word, after a random idle gap, and hold it until taken.
  task automatic send_texel(input texel_t texel);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_texel <= texel;
    do @(posedge clk); while (in_stall);
    sb.texel_accepted(texel);
    items_sent++;
  endtask

  task automatic send_texels(input int count, input int opaque_pct);
    texel_t texel;
    repeat (count) begin
      texel.red    = 8'($urandom);
      texel.green  = 8'($urandom);
      texel.blue   = 8'($urandom);
      texel.opaque = ($urandom_range(0, 99) < opaque_pct);
      send_texel(texel);
    end
  endtask

  // Stop sending, wait for every pending pixel word, then let the pipe empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int      cx, cy, w, h, n, opq;
    facing_e f;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a one-texel window at the origin, colour extremes.
    send_texel(texel_t'{8'hFF, 8'hFF, 8'hFF, 1'b1});
    send_texel(texel_t'{8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_texel(texel_t'{8'h00, 8'h00, 8'h00, 1'b1});
    wait_idle();

    // One small window per facing; a spare-index write midway through the south run must keep the scan.
    for (int i = 0; i < 4; i++) begin
      f = facing_e'(i);
      configure(10, 20, 3, 2, f);
      send_texels(2, 100);
      if (f == FACE_SOUTH) begin
        wait_idle();
        write_reg(IDX_SPARE_LO, '1);
      end
      send_texels(4, 75);
      wait_idle();
    end

    // Extreme settings: far off screen, saturated and zero sizes, screen edges.
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    configure(-2048, -2048, 0, 0, FACE_NORTH);
    send_texels(40, 100);
    wait_idle();
    configure(2047, 2047, 127, 127, FACE_EAST);
    send_texels(40, 100);
    wait_idle();
    configure(0, 0, 64, 64, FACE_SOUTH);
    send_texels(200, 90);
    wait_idle();
    configure(319, 239, 65, 100, FACE_WEST);
    send_texels(150, 90);
    wait_idle();
    configure(160, 120, 64, 1, FACE_EAST);
    send_texels(64, 90);
    wait_idle();

    // Long sink hold-off while texels keep coming, so the input backs up.
    configure(100, 100, 8, 8, FACE_NORTH);
    src_idle_pct  = 0;
    long_hold_req = 1'b1;
    send_texels(40, 100);
    wait_idle();

    // Random settings, each followed by a run of at most 160 random texels.
    while (items_sent < TOTAL_ITEMS - CALM_ITEMS) begin
      src_idle_pct  = pick_idle();
      sink_idle_pct = pick_idle();
      if ($urandom_range(0, 3) == 0) cx = int'($urandom_range(0, 4095)) - 2048;
      else cx = int'($urandom_range(0, 339)) - 10;
      if ($urandom_range(0, 3) == 0) cy = int'($urandom_range(0, 4095)) - 2048;
      else cy = int'($urandom_range(0, 259)) - 10;
      w = pick_size();
      h = pick_size();
      f = facing_e'($urandom_range(0, 3));
      configure(cx, cy, w, h, f);
      n = sb.effective_size(w) * sb.effective_size(h) * int'($urandom_range(1, 2)) +
          int'($urandom_range(0, 8));
      if (n > 160) n = $urandom_range(40, 160);
      opq = $urandom_range(50, 100);
      if ($urandom_range(0, 5) == 0) begin
        // Break the scan part way: either a spare index or a fresh facing.
        send_texels(n / 2, opq);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                    CFG_DATA_W'($urandom));
        end else begin
          write_reg(CFG_FACING, CFG_DATA_W'($urandom));
        end
        send_texels(n - n / 2, opq);
      end else begin
        send_texels(n, opq);
      end
      wait_idle();
    end

    // Final stretch at full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    configure(150, 110, 10, 10, FACE_WEST);
    send_texels(CALM_ITEMS, 90);
    wait_idle();

    $display("Sent %0d texel words over %0d register settings in all four facings;",
             sb.texels_seen, settings_used);
    $display("checked %0d pixel words, %0d mismatches.", sb.pixels_checked,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
